// ===== design/decimal_text_to_fixed_point_macros.svh =====
// Assertion macros used by the design file decimal_text_to_fixed_point.sv.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define DTFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define DTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DTFP_ASSERT(lbl, prop, msg)
`define DTFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/dtfp_pkg.sv =====
package dtfp_pkg;

	localparam int FRACTION_DIGITS = 8;
	// Width of the fraction digit counter (holds 0 .. FRACTION_DIGITS).
	localparam int FCW = $clog2(FRACTION_DIGITS + 2);

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Largest magnitude that any result may take (negative full scale).
	localparam logic [67:0] MAG_MAX = 68'h0_8000_0000_0000_0000;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SIGN  = 3'd1,
		PH_INT   = 3'd2,
		PH_POINT = 3'd3,
		PH_FRAC  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_NOINT    = 3'd2,
		ST_NOFRAC   = 3'd3,
		ST_PREC     = 3'd4,
		ST_INVALID  = 3'd5,
		ST_OVERFLOW = 3'd6
	} status_t;

	// Parse state handed to the finishing stage with the last character.
	typedef struct packed {
		status_t     err;
		phase_t      phase;
		logic        neg;
		logic        ovf;
		logic [63:0] mag;
	} fin_t;

	// Ten to the n, n from 0 to 19; zero outside that range.
	function automatic logic [63:0] pow10(input logic [4:0] n);
		logic [63:0] p;
		case (n)
			5'd0:  p = 64'd1;
			5'd1:  p = 64'd10;
			5'd2:  p = 64'd100;
			5'd3:  p = 64'd1000;
			5'd4:  p = 64'd10000;
			5'd5:  p = 64'd100000;
			5'd6:  p = 64'd1000000;
			5'd7:  p = 64'd10000000;
			5'd8:  p = 64'd100000000;
			5'd9:  p = 64'd1000000000;
			5'd10: p = 64'd10000000000;
			5'd11: p = 64'd100000000000;
			5'd12: p = 64'd1000000000000;
			5'd13: p = 64'd10000000000000;
			5'd14: p = 64'd100000000000000;
			5'd15: p = 64'd1000000000000000;
			5'd16: p = 64'd10000000000000000;
			5'd17: p = 64'd100000000000000000;
			5'd18: p = 64'd1000000000000000000;
			5'd19: p = 64'd10000000000000000000;
			default: p = 64'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== design/decimal_text_to_fixed_point.sv =====
// Throughput: one character per cycle, back to back, but a last character waits for
// room in the finish register. The accumulate (integer digit: scaled magnitude times
// ten plus digit weight; fraction digit: plus digit at its place) is combinational.
// Reset (arst_n low, asynchronous): pipeline empty, parser at start of text, no error.
// Stages: input register (_s1), finish register (_s2), output register (_q).
`include "decimal_text_to_fixed_point_macros.svh"

module decimal_text_to_fixed_point (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] character
	input  logic [0:0]  s_axis_tuser,  // [0] has_char
	input  logic        s_axis_tlast,  // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // [63:0] value, [66:64] status, [71:67] zero
);
	import dtfp_pkg::*;

	// ---------------------------------------------------------------
	// Handshake: each stage advances when the next has room, but s1 passes a non-last character on its own.
	// ---------------------------------------------------------------
	logic        s1_valid;
	logic [7:0]  s1_char;
	logic        s1_has;
	logic        s1_last;
	logic        s1_go;      // item in s1 is consumed this cycle
	logic        s2_valid;
	fin_t        s2_fin;
	logic        s2_ready;
	logic        out_ready;
	logic        m_valid_q;
	logic [63:0] value_q;
	status_t     status_q;

	assign out_ready     = ~m_valid_q | m_axis_tready;
	assign s2_ready      = ~s2_valid | out_ready;
	// A character that does not end the text leaves s1 without needing s2.
	assign s1_go         = s1_valid & (~s1_last | s2_ready);
	assign s_axis_tready = ~s1_valid | s1_go;

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_char <= s_axis_tdata;
			s1_has  <= s_axis_tuser[0];
			s1_last <= s_axis_tlast;
		end
	end

	// ---------------------------------------------------------------
	// Parser state. The magnitude is kept already scaled by ten to the
	// FRACTION_DIGITS: an integer digit multiplies it by ten and adds the
	// digit times the scale, a fraction digit adds the digit at its place.
	// Once the magnitude passes full scale the overflow flag sticks; the
	// magnitude only grows, so the flag is exact.
	// ---------------------------------------------------------------
	phase_t          phase_q, phase_n;
	status_t         err_q, err_n;
	logic            neg_q, neg_n;
	logic            ovf_q, ovf_n;
	logic [63:0]     mag_q, mag_n;
	logic [FCW-1:0]  cnt_q, cnt_n;

	logic            is_digit;
	logic [3:0]      dval;
	logic [4:0]      frac_exp;
	logic [67:0]     int_sum;
	logic [67:0]     frac_sum;

	assign is_digit = (s1_char >= CHAR_ZERO) && (s1_char <= CHAR_NINE);
	assign dval     = is_digit ? 4'(s1_char - CHAR_ZERO) : 4'd0;
	// Place of the next fraction digit; only used while digits remain.
	assign frac_exp = 5'(FRACTION_DIGITS - 1) - 5'(cnt_q);
	assign int_sum  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
		+ dval * pow10(5'(FRACTION_DIGITS));
	assign frac_sum = {4'b0, mag_q} + dval * pow10(frac_exp);

	always_comb begin
		phase_n = phase_q;
		err_n   = err_q;
		neg_n   = neg_q;
		ovf_n   = ovf_q;
		mag_n   = mag_q;
		cnt_n   = cnt_q;
		if (s1_has && err_q == ST_OK) begin
			case (phase_q)
				PH_START, PH_SIGN: begin
					if (phase_q == PH_START
						&& (s1_char == CHAR_PLUS || s1_char == CHAR_MINUS)) begin
						neg_n   = (s1_char == CHAR_MINUS);
						phase_n = PH_SIGN;
					end else if (is_digit) begin
						mag_n   = int_sum[63:0];
						ovf_n   = ovf_q | (int_sum > MAG_MAX);
						phase_n = PH_INT;
					end else begin
						err_n = ST_NOINT;
					end
				end
				PH_INT: begin
					if (is_digit) begin
						mag_n = int_sum[63:0];
						ovf_n = ovf_q | (int_sum > MAG_MAX);
					end else if (s1_char == CHAR_POINT) begin
						phase_n = PH_POINT;
					end else begin
						err_n = ST_INVALID;
					end
				end
				PH_POINT, PH_FRAC: begin
					if (!is_digit) begin
						err_n = (phase_q == PH_POINT) ? ST_NOFRAC : ST_INVALID;
					end else if (cnt_q >= FCW'(FRACTION_DIGITS)) begin
						err_n = ST_PREC;
					end else begin
						mag_n   = frac_sum[63:0];
						ovf_n   = ovf_q | (frac_sum > MAG_MAX);
						cnt_n   = cnt_q + 1'b1;
						phase_n = PH_FRAC;
					end
				end
				default: begin
					err_n = ST_INVALID;
				end
			endcase
		end
	end

	// Advance on every consumed character; clear for a new text after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			err_q   <= ST_OK;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			mag_q   <= '0;
			cnt_q   <= '0;
		end else if (s1_go) begin
			if (s1_last) begin
				phase_q <= PH_START;
				err_q   <= ST_OK;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
				mag_q   <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_n;
				err_q   <= err_n;
				neg_q   <= neg_n;
				ovf_q   <= ovf_n;
				mag_q   <= mag_n;
				cnt_q   <= cnt_n;
			end
		end
	end

	// ---------------------------------------------------------------
	// Finish register: hold the closing parse state of one text.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_ready) begin
			s2_valid <= s1_valid & s1_last;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_valid && s1_last) begin
			s2_fin.err   <= err_n;
			s2_fin.phase <= phase_n;
			s2_fin.neg   <= neg_n;
			s2_fin.ovf   <= ovf_n;
			s2_fin.mag   <= mag_n;
		end
	end

	// ---------------------------------------------------------------
	// Finish: turn the closing phase into a status, check range, zero errors, apply sign.
	// ---------------------------------------------------------------
	status_t     fin_status;
	logic [63:0] fin_limit;
	logic [63:0] fin_mag;
	logic [63:0] fin_value;

	assign fin_limit = s2_fin.neg ? MAG_MAX[63:0] : (MAG_MAX[63:0] - 64'd1);

	always_comb begin
		fin_status = s2_fin.err;
		if (s2_fin.err == ST_OK) begin
			case (s2_fin.phase)
				PH_START: fin_status = ST_EMPTY;
				PH_SIGN:  fin_status = ST_NOINT;
				PH_POINT: fin_status = ST_NOFRAC;
				PH_INT, PH_FRAC: begin
					if (s2_fin.ovf || s2_fin.mag > fin_limit) begin
						fin_status = ST_OVERFLOW;
					end
				end
				default:  fin_status = ST_INVALID;
			endcase
		end
	end

	assign fin_mag   = (fin_status == ST_OK) ? s2_fin.mag : 64'd0;
	assign fin_value = s2_fin.neg ? (64'd0 - fin_mag) : fin_mag;

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ready) begin
			m_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s2_valid) begin
			value_q  <= fin_value;
			status_q <= fin_status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, status_q, value_q};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`DTFP_ASSERT(a_err_value_zero, !m_valid_q || status_q == ST_OK || value_q == 64'd0, "error result carries a nonzero value")
	`DTFP_ASSERT(a_mag_in_range, ovf_q || {4'b0, mag_q} <= MAG_MAX, "magnitude beyond full scale without overflow flag")
	`DTFP_ASSERT_NEXT(a_clear_after_last, s1_go && s1_last, phase_q == PH_START && err_q == ST_OK && mag_q == 64'd0 && !ovf_q, "parser not cleared after end of text")
	`DTFP_ASSERT_NEXT(a_s2_hold, s2_valid && !out_ready, s2_valid && $stable(s2_fin), "finish stage lost or changed while stalled")

endmodule
